// ===== hw/rtl/quaternion_smallest_three_pack_macros.svh =====
// Assertion macros used by the checker of the quaternion packer.
// Each macro expects i_clk, and the first two also i_rst_n, to be visible where it is used.
`ifndef QUATERNION_SMALLEST_THREE_PACK_MACROS_SVH
`define QUATERNION_SMALLEST_THREE_PACK_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define QSTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define QSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define QSTP_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qstp_pkg.sv =====
package qstp_pkg;

    localparam int FRAC_BITS_DEF = 15;
    localparam int COMP_W        = 16;
    localparam int N_COMP        = 4;
    localparam int RAD_W         = 64;
    localparam int ROOT_W        = 32;
    localparam int REM_W         = 34;
    localparam int DIV_W         = 32;

    localparam logic DIR_PACK    = 1'b0;
    localparam logic DIR_UNPACK  = 1'b1;

    // Per-item data that rides along the arithmetic pipeline.
    typedef struct packed {
        logic [N_COMP-1:0][COMP_W-1:0] comp;
        logic [N_COMP-1:0][COMP_W-1:0] mag;
        logic                          mode;
        logic [1:0]                    idx;
        logic [1:0]                    big;
        logic                          zero;
        logic [COMP_W-1:0]             rebuilt;
    } t_side;

endpackage

// ===== hw/rtl/qstp_in_if.sv =====
interface qstp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] comp_a;
    logic signed [15:0] comp_b;
    logic signed [15:0] comp_c;
    logic signed [15:0] comp_d;
    logic [1:0]         dropped_index;

    modport source (output valid, output comp_a, output comp_b, output comp_c,
                    output comp_d, output dropped_index, input ready);
    modport sink   (input valid, input comp_a, input comp_b, input comp_c,
                    input comp_d, input dropped_index, output ready);
endinterface

// ===== hw/rtl/qstp_out_if.sv =====
interface qstp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] res_a;
    logic signed [15:0] res_b;
    logic signed [15:0] res_c;
    logic signed [15:0] res_d;
    logic [1:0]         largest_slot;
    logic               zero_length;

    modport source (output valid, output res_a, output res_b, output res_c,
                    output res_d, output largest_slot, output zero_length, input ready);
    modport sink   (input valid, input res_a, input res_b, input res_c,
                    input res_d, input largest_slot, input zero_length, output ready);
endinterface

// ===== hw/rtl/qstp_cfg_if.sv =====
interface qstp_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/quaternion_smallest_three_pack.sv =====
// Smallest-three quaternion packer and unpacker, fully pipelined. With direction 0 (pack)
// each item's four raw components are scaled to unit length in Q1.FRAC_BITS, rounded to
// nearest and saturated, the largest magnitude (lowest index on ties) is dropped after the
// sign is flipped so it would be positive, and its index comes out on largest_slot; an
// all-zero input gives zeros with zero_length set. With direction 1 (unpack) the missing
// component is rebuilt as the rounded square root of one minus the sum of squares and put
// back at dropped_index. One item enters and one result leaves per clock cycle while
// results are taken. An item passes FRAC_BITS + 39 register stages (54 at the default of
// 15): three front stages, a 32-stage square root, one setup stage, a divider with one
// stage per quotient bit (FRAC_BITS + 2), and the output register. When the result is
// not taken the whole pipeline holds, so nothing is dropped or repeated. The direction
// register should only be written while the pipeline is empty.
module quaternion_smallest_three_pack #(
    parameter int FRAC_BITS = qstp_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qstp_in_if.sink       i_in,
    qstp_out_if.source    o_out,
    qstp_cfg_if.sink      i_cfg
);

    // Quotient bits per lane; one more than needed to see values just above one.
    localparam int QB         = FRAC_BITS + 2;
    // The length is taken as sqrt(S * 2^NORM_SHIFT), i.e. with NORM_SHIFT/2 fraction bits.
    localparam int NORM_SHIFT = 30;
    localparam int SHIFT      = FRAC_BITS + NORM_SHIFT / 2;
    localparam int NUM_W      = FRAC_BITS + 32;
    localparam int SAT_MAX    = (FRAC_BITS < 15) ? ((1 << FRAC_BITS) - 1) : 32767;
    localparam int NL         = qstp_pkg::N_COMP;
    localparam int CW         = qstp_pkg::COMP_W;
    localparam int DW         = qstp_pkg::DIV_W;

    // Global advance: every stage moves when the output register is free or being taken.
    logic w_en;
    logic r_o_valid;

    assign w_en        = !r_o_valid || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    // Direction register; a transfer on the configuration channel always writes it.
    logic r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= qstp_pkg::DIR_PACK;
        end else if (i_cfg.valid) begin
            r_dir <= i_cfg.data;
        end
    end

    // Stage 1: capture the item, take absolute values.
    qstp_pkg::t_side n_s1, r_s1;
    logic            r_v1;

    always_comb begin
        n_s1         = '0;
        n_s1.comp[0] = i_in.comp_a;
        n_s1.comp[1] = i_in.comp_b;
        n_s1.comp[2] = i_in.comp_c;
        n_s1.comp[3] = i_in.comp_d;
        for (int i = 0; i < NL; i++) begin
            n_s1.mag[i] = n_s1.comp[i][CW-1] ? CW'(-n_s1.comp[i]) : n_s1.comp[i];
        end
        n_s1.mode = r_dir;
        n_s1.idx  = i_in.dropped_index;
    end

    // Stage 2: squares of the magnitudes and the largest-magnitude search.
    // Ties keep the lower index because only a strictly larger value wins.
    qstp_pkg::t_side      n_s2, r_s2;
    logic                 r_v2;
    logic [NL-1:0][31:0]  r_sq;

    always_comb begin
        logic [1:0]    lo_b, hi_b;
        logic [CW-1:0] lo_m, hi_m;
        lo_b = (r_s1.mag[1] > r_s1.mag[0]) ? 2'd1 : 2'd0;
        lo_m = (r_s1.mag[1] > r_s1.mag[0]) ? r_s1.mag[1] : r_s1.mag[0];
        hi_b = (r_s1.mag[3] > r_s1.mag[2]) ? 2'd3 : 2'd2;
        hi_m = (r_s1.mag[3] > r_s1.mag[2]) ? r_s1.mag[3] : r_s1.mag[2];
        n_s2     = r_s1;
        n_s2.big = (hi_m > lo_m) ? hi_b : lo_b;
    end

    // Stage 3: sums of squares and the radicand for the shared square root.
    // Pack takes sqrt(S * 2^30); unpack takes sqrt(1 - a^2 - b^2 - c^2), floored at zero.
    qstp_pkg::t_side                 n_s3, r_s3;
    logic                            r_v3;
    logic [qstp_pkg::RAD_W-1:0]      n_rad, r_rad;

    always_comb begin
        logic [33:0]                 sum4, sum3;
        logic [qstp_pkg::RAD_W-1:0]  one2, rem;
        sum4  = 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]) + 34'(r_sq[3]);
        sum3  = 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
        one2  = qstp_pkg::RAD_W'(1) << (2 * FRAC_BITS);
        rem   = (qstp_pkg::RAD_W'(sum3) < one2) ? (one2 - qstp_pkg::RAD_W'(sum3)) : '0;
        n_s3  = r_s2;
        if (r_s2.mode == qstp_pkg::DIR_PACK) begin
            n_rad     = qstp_pkg::RAD_W'(sum4) << NORM_SHIFT;
            n_s3.zero = (sum4 == '0);
        end else begin
            n_rad     = rem;
            n_s3.zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            for (int i = 0; i < NL; i++) begin
                r_sq[i] <= 32'(r_s1.mag[i]) * 32'(r_s1.mag[i]);
            end
            r_s3  <= n_s3;
            r_rad <= n_rad;
        end
    end

    // Square root: the vector length for pack, the rebuilt component for unpack.
    logic                          w_sq_valid;
    logic [qstp_pkg::ROOT_W-1:0]   w_root;
    logic [qstp_pkg::REM_W-1:0]    w_rem;
    qstp_pkg::t_side               w_sq_side;

    qstp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_rad   (r_rad),
        .i_side  (r_s3),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_rem   (w_rem),
        .o_side  (w_sq_side)
    );

    // Setup stage: round the rebuilt component, and form each lane's numerator
    // |x| * 2^(FRAC_BITS+15) + floor(m/2). Its high part is already below m, so
    // only the low QB bits need a division step each.
    qstp_pkg::t_side        n_ps, r_ps;
    logic                   r_pv;
    logic [DW-1:0]          r_m;
    logic [NL-1:0][DW-1:0]  n_part, r_part;
    logic [NL-1:0][QB-1:0]  n_low, r_low;

    always_comb begin
        logic [qstp_pkg::ROOT_W:0] rounded;
        logic [NUM_W-1:0]          num;
        rounded = (qstp_pkg::ROOT_W + 1)'(w_root)
                + (qstp_pkg::ROOT_W + 1)'(w_rem > qstp_pkg::REM_W'(w_root));
        n_ps         = w_sq_side;
        n_ps.rebuilt = (rounded > (qstp_pkg::ROOT_W + 1)'(SAT_MAX)) ? CW'(SAT_MAX)
                                                                    : CW'(rounded);
        for (int i = 0; i < NL; i++) begin
            num       = (NUM_W'(w_sq_side.mag[i]) << SHIFT) + NUM_W'(w_root >> 1);
            n_part[i] = DW'(num >> QB);
            n_low[i]  = num[QB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ps   <= n_ps;
            r_m    <= DW'(w_root);
            r_part <= n_part;
            r_low  <= n_low;
        end
    end

    // Four-lane divider by the common length.
    logic                   w_dv_valid;
    logic [NL-1:0][QB-1:0]  w_quo;
    qstp_pkg::t_side        w_dv_side;

    qstp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_pv),
        .i_divisor (r_m),
        .i_part    (r_part),
        .i_low     (r_low),
        .i_side    (r_ps),
        .o_valid   (w_dv_valid),
        .o_quo     (w_quo),
        .o_side    (w_dv_side)
    );

    // Output stage: saturate, fix signs so the dropped component is positive,
    // then either drop it (pack) or insert the rebuilt one (unpack).
    logic [NL-1:0][CW-1:0] n_res, r_res;
    logic [1:0]            n_slot, r_slot;
    logic                  n_zero, r_zero;

    always_comb begin
        logic [NL-1:0][CW-1:0] q;
        logic [CW-1:0]         qm;
        logic                  flip;
        for (int i = 0; i < NL; i++) begin
            qm   = (w_quo[i] > QB'(SAT_MAX)) ? CW'(SAT_MAX) : CW'(w_quo[i]);
            flip = w_dv_side.comp[i][CW-1] ^ w_dv_side.comp[w_dv_side.big][CW-1];
            q[i] = flip ? CW'(-qm) : qm;
        end
        n_res  = '0;
        n_slot = 2'd0;
        n_zero = 1'b0;
        if (w_dv_side.mode == qstp_pkg::DIR_PACK) begin
            if (w_dv_side.zero) begin
                n_zero = 1'b1;
            end else begin
                n_res[0] = (w_dv_side.big == 2'd0) ? q[1] : q[0];
                n_res[1] = (w_dv_side.big <= 2'd1) ? q[2] : q[1];
                n_res[2] = (w_dv_side.big <= 2'd2) ? q[3] : q[2];
                n_slot   = w_dv_side.big;
            end
        end else begin
            n_res[0] = (w_dv_side.idx == 2'd0) ? w_dv_side.rebuilt : w_dv_side.comp[0];
            n_res[1] = (w_dv_side.idx == 2'd0) ? w_dv_side.comp[0] :
                       (w_dv_side.idx == 2'd1) ? w_dv_side.rebuilt : w_dv_side.comp[1];
            n_res[2] = (w_dv_side.idx <= 2'd1) ? w_dv_side.comp[1] :
                       (w_dv_side.idx == 2'd2) ? w_dv_side.rebuilt : w_dv_side.comp[2];
            n_res[3] = (w_dv_side.idx == 2'd3) ? w_dv_side.rebuilt : w_dv_side.comp[2];
            n_slot   = w_dv_side.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res  <= n_res;
            r_slot <= n_slot;
            r_zero <= n_zero;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.res_a        = r_res[0];
    assign o_out.res_b        = r_res[1];
    assign o_out.res_c        = r_res[2];
    assign o_out.res_d        = r_res[3];
    assign o_out.largest_slot = r_slot;
    assign o_out.zero_length  = r_zero;

endmodule

// ===== hw/rtl/qstp_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
module qstp_sqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [qstp_pkg::RAD_W-1:0]         i_rad,
    input  qstp_pkg::t_side                    i_side,
    output logic                               o_valid,
    output logic [qstp_pkg::ROOT_W-1:0]        o_root,
    output logic [qstp_pkg::REM_W-1:0]         o_rem,
    output qstp_pkg::t_side                    o_side
);

    localparam int ST = qstp_pkg::ROOT_W;
    localparam int RW = qstp_pkg::RAD_W;
    localparam int MW = qstp_pkg::REM_W;
    localparam int QW = qstp_pkg::ROOT_W;

    logic            r_v    [ST];
    logic [RW-1:0]   r_rad  [ST];
    logic [MW-1:0]   r_rem  [ST];
    logic [QW-1:0]   r_root [ST];
    qstp_pkg::t_side r_side [ST];

    for (genvar k = 0; k < ST; k++) begin : g_st
        logic            pv;
        logic [RW-1:0]   prad;
        logic [MW-1:0]   prem;
        logic [QW-1:0]   proot;
        qstp_pkg::t_side pside;
        logic [MW+1:0]   trial;
        logic [MW+1:0]   tsub;
        logic            ge;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign prad  = i_rad;
            assign prem  = '0;
            assign proot = '0;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign prad  = r_rad[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign pside = r_side[k-1];
        end

        assign trial = {prem, prad[RW-1:RW-2]};
        assign tsub  = {2'b00, proot, 2'b01};
        assign ge    = (trial >= tsub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {prad[RW-3:0], 2'b00};
                r_rem[k]  <= ge ? MW'(trial - tsub) : trial[MW-1:0];
                r_root[k] <= {proot[QW-2:0], ge};
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[ST-1];
    assign o_root  = r_root[ST-1];
    assign o_rem   = r_rem[ST-1];
    assign o_side  = r_side[ST-1];

endmodule

// ===== hw/rtl/qstp_div.sv =====
// Pipelined restoring divider, four lanes sharing one divisor,
// one quotient bit per stage.
module qstp_div #(
    parameter int FRAC_BITS = qstp_pkg::FRAC_BITS_DEF
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_en,
    input  logic                                                    i_valid,
    input  logic [qstp_pkg::DIV_W-1:0]                              i_divisor,
    input  logic [qstp_pkg::N_COMP-1:0][qstp_pkg::DIV_W-1:0]        i_part,
    input  logic [qstp_pkg::N_COMP-1:0][FRAC_BITS+1:0]              i_low,
    input  qstp_pkg::t_side                                         i_side,
    output logic                                                    o_valid,
    output logic [qstp_pkg::N_COMP-1:0][FRAC_BITS+1:0]              o_quo,
    output qstp_pkg::t_side                                         o_side
);

    localparam int QB = FRAC_BITS + 2;
    localparam int DW = qstp_pkg::DIV_W;
    localparam int NL = qstp_pkg::N_COMP;

    logic                      r_v    [QB];
    logic [DW-1:0]             r_div  [QB];
    logic [NL-1:0][DW-1:0]     r_part [QB];
    logic [NL-1:0][QB-1:0]     r_low  [QB];
    qstp_pkg::t_side           r_side [QB];

    for (genvar k = 0; k < QB; k++) begin : g_st
        logic                  pv;
        logic [DW-1:0]         pdiv;
        logic [NL-1:0][DW-1:0] ppart;
        logic [NL-1:0][QB-1:0] plow;
        qstp_pkg::t_side       pside;
        logic [NL-1:0][DW-1:0] n_part;
        logic [NL-1:0][QB-1:0] n_low;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign pdiv  = i_divisor;
            assign ppart = i_part;
            assign plow  = i_low;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign pdiv  = r_div[k-1];
            assign ppart = r_part[k-1];
            assign plow  = r_low[k-1];
            assign pside = r_side[k-1];
        end

        // The numerator bits shift out of the low word as quotient bits shift in.
        always_comb begin
            logic [DW:0] trial;
            logic        ge;
            for (int l = 0; l < NL; l++) begin
                trial     = {ppart[l], plow[l][QB-1]};
                ge        = (trial >= {1'b0, pdiv});
                n_part[l] = ge ? DW'(trial - {1'b0, pdiv}) : DW'(trial);
                n_low[l]  = {plow[l][QB-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[k]  <= pdiv;
                r_part[k] <= n_part;
                r_low[k]  <= n_low;
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_quo   = r_low[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

// ===== hw/rtl/qstp_chk.sv =====
// Port-level checks on the result channel of the quaternion packer.
module qstp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_res_a,
    input logic [15:0] i_res_b,
    input logic [15:0] i_res_c,
    input logic [15:0] i_res_d,
    input logic [1:0]  i_slot,
    input logic        i_zero
);

`include "quaternion_smallest_three_pack_macros.svh"

    logic        w_stall;
    logic [66:0] w_payload;
    logic        w_res_zero;

    assign w_stall    = i_out_valid && !i_out_ready;
    assign w_payload  = {i_res_a, i_res_b, i_res_c, i_res_d, i_slot, i_zero};
    assign w_res_zero = (i_res_a == 16'd0) && (i_res_b == 16'd0) && (i_res_c == 16'd0)
                        && (i_res_d == 16'd0) && (i_slot == 2'd0);

    // A result offered but not taken stays offered.
    `QSTP_ASSERT_NEXT(a_valid_hold, w_stall, i_out_valid, "result valid dropped before transfer")

    // A stalled result keeps its payload.
    `QSTP_ASSERT_NEXT(a_payload_hold, w_stall, $stable(w_payload), "stalled result changed")

    // A zero-length input yields an all-zero result with slot zero.
    `QSTP_ASSERT_NOW(a_zero_result, i_out_valid && i_zero, w_res_zero, "zero result not all zero")

    // Reset empties the pipeline, so no result is offered right after it.
    `QSTP_ASSERT_RST(a_reset_empty, !i_rst_n, !i_out_valid, "result offered right after reset")

endmodule

bind quaternion_smallest_three_pack qstp_chk u_qstp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_a     (o_out.res_a),
    .i_res_b     (o_out.res_b),
    .i_res_c     (o_out.res_c),
    .i_res_d     (o_out.res_d),
    .i_slot      (o_out.largest_slot),
    .i_zero      (o_out.zero_length)
);

// ===== tb/qstp_tb_if.sv =====
`timescale 1ns / 1ps

// The block's own interfaces are used as they stand. This file holds a small
// record type for the stored expected results.
package qstp_tb_pkg;

    typedef struct {
        logic signed [15:0] res_a;
        logic signed [15:0] res_b;
        logic signed [15:0] res_c;
        logic signed [15:0] res_d;
        logic [1:0]         largest_slot;
        logic               zero_length;
    } t_rot_result;

endpackage

// ===== tb/tb_quaternion_smallest_three_pack.sv =====
`timescale 1ns / 1ps

module tb_quaternion_smallest_three_pack;

    localparam int FRAC        = 15;
    localparam int LATENCY     = FRAC + 39;
    localparam longint SAT_TOP = 32767;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qstp_in_if  in_ch ();
    qstp_out_if out_ch ();
    qstp_cfg_if cfg_ch ();

    quaternion_smallest_three_pack #(.FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // The testbench's copy of the direction register.
    logic                     mode_shadow = qstp_pkg::DIR_PACK;
    qstp_tb_pkg::t_rot_result pending_rotations[$];
    int                       mismatch_count = 0;
    int                       results_seen = 0;
    int                       items_sent = 0;
    int                       pack_sent = 0;
    int                       unpack_sent = 0;
    int                       send_idle_pct = 0;
    int                       take_idle_pct = 0;
    longint                   cycle_count = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The run is ended here if it runs past its cycle limit, as when the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d results pending", pending_rotations.size());
            $display("status: fail");
            $finish;
        end
    end

    // Bitwise integer square root, floor.
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v    -= root + bit_w;
                root  = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    // Computes what the block should return for one rotation in the current mode.
    function automatic qstp_tb_pkg::t_rot_result predict_rotation(
        logic signed [15:0] a, logic signed [15:0] b,
        logic signed [15:0] c, logic signed [15:0] d,
        logic [1:0] idx);
        qstp_tb_pkg::t_rot_result res;
        longint          comp[4];
        longint          scaled[4];
        longint          outv[4];
        longint unsigned mag[4];
        longint unsigned sum_sq;
        longint unsigned norm;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned root;
        int              big;
        int              k;
        comp[0] = a;
        comp[1] = b;
        comp[2] = c;
        comp[3] = d;
        outv    = '{0, 0, 0, 0};
        res.zero_length  = 1'b0;
        res.largest_slot = 2'd0;
        if (mode_shadow == qstp_pkg::DIR_PACK) begin
            sum_sq = 0;
            for (int i = 0; i < 4; i++) begin
                mag[i]  = comp[i] < 0 ? -comp[i] : comp[i];
                sum_sq += mag[i] * mag[i];
            end
            if (sum_sq == 0) begin
                res.zero_length = 1'b1;
            end else begin
                norm = floor_root(sum_sq << 30);
                for (int i = 0; i < 4; i++) begin
                    quo = ((mag[i] << (FRAC + 15)) + (norm >> 1)) / norm;
                    if (quo > SAT_TOP) quo = SAT_TOP;
                    scaled[i] = comp[i] < 0 ? -longint'(quo) : longint'(quo);
                end
                big = 0;
                for (int i = 1; i < 4; i++) if (mag[i] > mag[big]) big = i;
                if (comp[big] < 0) for (int i = 0; i < 4; i++) scaled[i] = -scaled[i];
                k = 0;
                for (int i = 0; i < 4; i++) begin
                    if (i != big) begin
                        outv[k] = scaled[i];
                        k++;
                    end
                end
                res.largest_slot = big[1:0];
            end
        end else begin
            sum_sq = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i]  = comp[i] < 0 ? -comp[i] : comp[i];
                sum_sq += mag[i] * mag[i];
            end
            rem  = sum_sq < (64'd1 << (2 * FRAC)) ? (64'd1 << (2 * FRAC)) - sum_sq : 0;
            root = floor_root(rem);
            if (rem - root * root > root) root++;
            if (root > SAT_TOP) root = SAT_TOP;
            k = 0;
            for (int i = 0; i < 4; i++) begin
                if (i == idx) begin
                    outv[i] = root;
                end else begin
                    outv[i] = comp[k];
                    k++;
                end
            end
            res.largest_slot = idx;
        end
        res.res_a = outv[0][15:0];
        res.res_b = outv[1][15:0];
        res.res_c = outv[2][15:0];
        res.res_d = outv[3][15:0];
        return res;
    endfunction

    // Sends one rotation and records its expected result at the transfer.
    // Valid is left high afterwards; a drain, or an idle turn of the next send, takes it down.
    task automatic send_rotation(logic signed [15:0] a, logic signed [15:0] b,
                                 logic signed [15:0] c, logic signed [15:0] d, logic [1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.comp_a        <= a;
        in_ch.comp_b        <= b;
        in_ch.comp_c        <= c;
        in_ch.comp_d        <= d;
        in_ch.dropped_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_rotations = {pending_rotations, predict_rotation(a, b, c, d, idx)};
        items_sent++;
        if (mode_shadow == qstp_pkg::DIR_PACK) pack_sent++;
        else unpack_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_rotations.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // The direction is only changed once the pipeline has emptied.
    task automatic write_direction(logic dir);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= dir;
        do @(posedge i_clk); while (!cfg_ch.ready);
        mode_shadow = dir;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Output side: random backpressure, and each transfer is checked in order.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge i_clk) begin
        qstp_tb_pkg::t_rot_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_rotations.size() == 0) begin
                $error("result arrived with nothing expected");
                mismatch_count++;
            end else begin
                want = pending_rotations.pop_front();
                if (out_ch.res_a !== want.res_a) begin
                    $error("res_a expected %0d got %0d", want.res_a, out_ch.res_a);
                    mismatch_count++;
                end
                if (out_ch.res_b !== want.res_b) begin
                    $error("res_b expected %0d got %0d", want.res_b, out_ch.res_b);
                    mismatch_count++;
                end
                if (out_ch.res_c !== want.res_c) begin
                    $error("res_c expected %0d got %0d", want.res_c, out_ch.res_c);
                    mismatch_count++;
                end
                if (out_ch.res_d !== want.res_d) begin
                    $error("res_d expected %0d got %0d", want.res_d, out_ch.res_d);
                    mismatch_count++;
                end
                if (out_ch.largest_slot !== want.largest_slot) begin
                    $error("largest_slot expected %0d got %0d", want.largest_slot,
                           out_ch.largest_slot);
                    mismatch_count++;
                end
                if (out_ch.zero_length !== want.zero_length) begin
                    $error("zero_length expected %0d got %0d", want.zero_length,
                           out_ch.zero_length);
                    mismatch_count++;
                end
            end
        end
    end

    // Random component, weighted toward extremes and small values.
    function automatic logic signed [15:0] pick_comp();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(8)) - 4);
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // A kept-component value for unpack: mostly a plausible unit-quaternion part.
    function automatic logic signed [15:0] pick_kept();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(37000)) - 18500);
    endfunction

    task automatic test_pack_directed();
        send_rotation(0, 0, 0, 0, 2'd3);
        send_rotation(16'sh7fff, 0, 0, 0, 0);
        send_rotation(16'sh8000, 0, 0, 0, 0);
        send_rotation(0, 0, 0, 16'sh8000, 0);
        send_rotation(5, -5, 5, -5, 0);
        send_rotation(-5, 5, 5, -5, 0);
        send_rotation(1, 2, -3, 3, 0);
        send_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_rotation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_rotation(0, -1, 0, 0, 0);
        send_rotation(100, 200, -300, 250, 1);
        send_rotation(16'shffff, 16'sh5555, 16'shaaaa, 16'sh1234, 2);
    endtask

    task automatic test_unpack_directed();
        for (int i = 0; i < 4; i++) send_rotation(0, 0, 0, 16'sh7fff, i[1:0]);
        send_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1);
        send_rotation(16'sh7fff, 0, 0, 0, 2);
        send_rotation(16384, 16384, 16384, 0, 3);
        send_rotation(-16384, 16384, -16384, 16'sh5555, 0);
        send_rotation(1, -1, 1, 0, 3);
        send_rotation(16'shaaaa, 16'sh5555, 16'shffff, 0, 1);
    endtask

    task automatic test_random_mixed(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 20) write_direction(logic'($urandom_range(1)));
            if (n == count / 2) wait_drained();
            if (mode_shadow == qstp_pkg::DIR_PACK)
                send_rotation(pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                              2'($urandom));
            else
                send_rotation(pick_kept(), pick_kept(), pick_kept(), 16'($urandom),
                              2'($urandom));
        end
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.comp_a        = '0;
        in_ch.comp_b        = '0;
        in_ch.comp_c        = '0;
        in_ch.comp_d        = '0;
        in_ch.dropped_index = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        take_idle_pct = 65;
        test_pack_directed();
        write_direction(qstp_pkg::DIR_UNPACK);
        test_unpack_directed();
        write_direction(qstp_pkg::DIR_PACK);
        test_random_mixed(130);

        send_idle_pct = 65;
        take_idle_pct = 11;
        test_random_mixed(130);

        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random_mixed(130);
        write_direction(qstp_pkg::DIR_UNPACK);
        test_random_mixed(10);

        wait_drained();
        $display("covered %0d rotations (%0d packed, %0d unpacked), %0d results checked",
                 items_sent, pack_sent, unpack_sent, results_seen);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qstp_pkg.sv
hw/rtl/qstp_in_if.sv
hw/rtl/qstp_out_if.sv
hw/rtl/qstp_cfg_if.sv
hw/rtl/qstp_sqrt.sv
hw/rtl/qstp_div.sv
hw/rtl/quaternion_smallest_three_pack.sv
hw/rtl/qstp_chk.sv
tb/qstp_tb_if.sv
tb/tb_quaternion_smallest_three_pack.sv
